/* design/msc_pkg.sv */
// Shared types, constants and clamp helpers for the modulation source combiner.
package msc_pkg;

    localparam int MAX_SOURCES_DEF = 4;

    localparam int RAW_W      = 17;
    localparam int GAIN_W     = 18;
    localparam int PROD_W     = RAW_W + GAIN_W - 1;
    localparam int TERM_W     = 15;
    localparam int VALUE_W    = 14;
    localparam int COUNT_W    = 3;
    localparam int MASK_W     = 4;
    localparam int MODES_W    = 16;
    localparam int MODE_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int SCALE_SHIFT = 15;

    localparam logic [VALUE_W-1:0] CENTER  = 14'h2000;
    localparam logic [VALUE_W-1:0] UNI_MAX = 14'h3FFF;
    localparam logic signed [GAIN_W-1:0] GAIN_UNITY = 18'sh10000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIPOLAR_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_MODES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_ZERO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_ONE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_TWO     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_THREE   = 3'd6;

    // Combine modes; every other code keeps the running value.
    localparam logic [MODE_W-1:0] MODE_SET = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ADD = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SUB = 4'd3;

    // Running value and its bipolar flag, handed from one combine stage to the next.
    typedef struct packed {
        logic               bipolar;
        logic [VALUE_W-1:0] value;
    } acc_t;

    // Clamp to -0x2000..0x1FFF and move onto the 0x2000 centre.
    function automatic logic [VALUE_W-1:0] clamp_bip(input logic signed [31:0] r);
        logic [VALUE_W-1:0] res;
        if (r < -32'sd8192) begin
            res = '0;
        end else if (r > 32'sd8191) begin
            res = UNI_MAX;
        end else begin
            res = r[VALUE_W-1:0] + CENTER;
        end
        return res;
    endfunction

    // Clamp to 0..0x3FFF.
    function automatic logic [VALUE_W-1:0] clamp_uni(input logic signed [31:0] r);
        logic [VALUE_W-1:0] res;
        if (r < 32'sd0) begin
            res = '0;
        end else if (r > 32'sd16383) begin
            res = UNI_MAX;
        end else begin
            res = r[VALUE_W-1:0];
        end
        return res;
    endfunction

endpackage

/* design/msc_scale.sv */
// One scaling lane: gain multiply in the first stage, shift and clamp in the second.
module msc_scale
    import msc_pkg::*;
(
    input  logic                     clk,
    input  logic                     load_prod,
    input  logic                     load_term,
    input  logic signed [RAW_W-1:0]  raw,
    input  logic signed [GAIN_W-1:0] gain,
    input  logic                     bipolar,
    output logic signed [TERM_W-1:0] term
);

    logic signed [GAIN_W-2:0] gain_half;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] shifted;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [TERM_W-1:0] term_next;

    // The gain is halved with a floor before the product is taken.
    assign gain_half = gain[GAIN_W-1:1];
    assign prod_next = raw * gain_half;

    always_ff @(posedge clk) begin
        if (load_prod) begin
            prod_reg <= prod_next;
        end
    end

    assign shifted = prod_reg >>> SCALE_SHIFT;

    always_comb begin
        if (bipolar) begin
            if (shifted < -34'sd8192) begin
                term_next = -15'sd8192;
            end else if (shifted > 34'sd8191) begin
                term_next = 15'sd8191;
            end else begin
                term_next = shifted[TERM_W-1:0];
            end
        end else begin
            // A negative unipolar term is held at zero.
            if (shifted < 34'sd0) begin
                term_next = '0;
            end else if (shifted > 34'sd16383) begin
                term_next = 15'sd16383;
            end else begin
                term_next = shifted[TERM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (load_term) begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

/* design/msc_combine.sv */
// One combine stage: folds one scaled term into the running value.
module msc_combine
    import msc_pkg::*;
#(
    parameter int NUM_SRC = MAX_SOURCES_DEF
)
(
    input  logic                            clk,
    input  logic                            load,
    input  logic                            active,
    input  logic                            bipolar,
    input  logic [MODE_W-1:0]               mode,
    input  logic signed [TERM_W-1:0]        term,
    input  logic [NUM_SRC-1:0][TERM_W-1:0]  terms_in,
    input  acc_t                            acc_in,
    output logic [NUM_SRC-1:0][TERM_W-1:0]  terms_out,
    output acc_t                            acc_out
);

    logic signed [15:0] base;
    logic signed [16:0] sum_add;
    logic signed [16:0] sum_sub;
    logic signed [30:0] prod;
    logic signed [30:0] prod_sh;
    logic               mul_bip;
    acc_t               acc_next;
    acc_t               acc_reg;
    logic [NUM_SRC-1:0][TERM_W-1:0] terms_reg;

    // With a bipolar running value the arithmetic works on the offset from centre.
    always_comb begin
        if (acc_in.bipolar) begin
            base = $signed({2'b00, acc_in.value}) - 16'sh2000;
        end else begin
            base = $signed({2'b00, acc_in.value});
        end
    end

    assign sum_add = {base[15], base} + {{2{term[TERM_W-1]}}, term};
    assign sum_sub = {base[15], base} - {{2{term[TERM_W-1]}}, term};
    assign prod    = base * term;
    assign prod_sh = bipolar ? (prod >>> 13) : (prod >>> 14);
    assign mul_bip = bipolar | acc_in.bipolar;

    always_comb begin
        acc_next = acc_in;
        if (active) begin
            unique case (mode)
                MODE_SET: begin
                    acc_next.bipolar = bipolar;
                    acc_next.value   = bipolar ? (term[VALUE_W-1:0] + CENTER)
                                               : term[VALUE_W-1:0];
                end
                MODE_ADD: begin
                    acc_next.value = acc_in.bipolar ? clamp_bip(32'(sum_add))
                                                    : clamp_uni(32'(sum_add));
                end
                MODE_MUL: begin
                    acc_next.bipolar = mul_bip;
                    acc_next.value   = mul_bip ? clamp_bip(32'(prod_sh))
                                               : clamp_uni(32'(prod_sh));
                end
                MODE_SUB: begin
                    acc_next.value = acc_in.bipolar ? clamp_bip(32'(sum_sub))
                                                    : clamp_uni(32'(sum_sub));
                end
                default: begin
                    acc_next = acc_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            acc_reg   <= acc_next;
            terms_reg <= terms_in;
        end
    end

    assign acc_out   = acc_reg;
    assign terms_out = terms_reg;

endmodule

/* design/modulation_source_combiner.sv */
// Top level of the modulation source combiner: configuration, lanes and pipeline control.
//
// Usage: a source transaction on src_valid/src_ready carries four raw 17-bit source
// values. Each result transaction on res_valid/res_ready carries one 14-bit control
// value, combined_value, in the same order as the sources were taken.
// Configuration is written through cfg_write/cfg_index/cfg_data, one register per cycle,
// no wait state. Users must write only while no transaction is in flight; not enforced.
// A transaction passes 2 + MAX_SOURCES register stages: one for the gain multiply,
// one for the shift and clamp of each term, and one combine stage per source, each
// holding a single multiplier. The first stage is loaded at the accepting edge. An
// item may enter every cycle while res_ready stays high, so the sustained rate is
// one transaction per cycle.
// Every stage has its own valid bit and moves whenever the stage after it is empty
// or moving, so a stalled receiver only backs up the pipeline as far as it is full;
// empty stages behind the output register still take new transactions.
// Reset clears every valid bit and returns the registers to no sources, unipolar
// sources, mode set and unity gain; it produces no result.
module modulation_source_combiner
    import msc_pkg::*;
#(
    parameter int MAX_SOURCES = MAX_SOURCES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     src_valid,
    output logic                     src_ready,
    input  logic signed [RAW_W-1:0]  source_zero_value,
    input  logic signed [RAW_W-1:0]  source_one_value,
    input  logic signed [RAW_W-1:0]  source_two_value,
    input  logic signed [RAW_W-1:0]  source_three_value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [VALUE_W-1:0]       combined_value
);

    // Pipeline layout: stage 0 product, stage 1 term, stages 2.. combine.
    localparam int NST = 2 + MAX_SOURCES;

    logic [COUNT_W-1:0]      source_count_reg;
    logic [MASK_W-1:0]       bipolar_mask_reg;
    logic [MODES_W-1:0]      combine_modes_reg;
    logic signed [GAIN_W-1:0] gain_reg [MASK_W];
    logic [COUNT_W-1:0]      count_eff;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] prev_vld;
    logic [NST:0]   rdy;
    logic [NST-1:0] load;

    logic signed [RAW_W-1:0] raw [MASK_W];
    logic [MAX_SOURCES-1:0][TERM_W-1:0] terms_s1;
    logic [MAX_SOURCES-1:0][TERM_W-1:0] terms_pipe [MAX_SOURCES+1];
    acc_t acc_pipe [MAX_SOURCES+1];

    // Configuration registers; the user must write only with the pipeline empty (unchecked).
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            source_count_reg  <= '0;
            bipolar_mask_reg  <= '0;
            combine_modes_reg <= '0;
            for (int g = 0; g < MASK_W; g++) begin
                gain_reg[g] <= GAIN_UNITY;
            end
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_SOURCE_COUNT:  source_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_BIPOLAR_MASK:  bipolar_mask_reg  <= cfg_data[MASK_W-1:0];
                CFG_COMBINE_MODES: combine_modes_reg <= cfg_data[MODES_W-1:0];
                CFG_SCALE_ZERO:    gain_reg[0]       <= $signed(cfg_data);
                CFG_SCALE_ONE:     gain_reg[1]       <= $signed(cfg_data);
                CFG_SCALE_TWO:     gain_reg[2]       <= $signed(cfg_data);
                CFG_SCALE_THREE:   gain_reg[3]       <= $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    // A count above the number of built stages saturates.
    assign count_eff = (source_count_reg > COUNT_W'(MAX_SOURCES)) ? COUNT_W'(MAX_SOURCES)
                                                                  : source_count_reg;

    // Per-stage flow control: a stage takes new data when it is empty or draining.
    always_comb begin
        rdy[NST] = res_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        prev_vld[0] = src_valid;
        for (int k = 1; k < NST; k++) begin
            prev_vld[k] = vld_reg[k-1];
        end
        for (int k = 0; k < NST; k++) begin
            load[k]     = rdy[k] && prev_vld[k];
            vld_next[k] = rdy[k] ? prev_vld[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign raw[0] = source_zero_value;
    assign raw[1] = source_one_value;
    assign raw[2] = source_two_value;
    assign raw[3] = source_three_value;

    // Scaling lanes, one per source, working side by side.
    for (genvar s = 0; s < MAX_SOURCES; s++) begin : g_lane
        msc_scale u_scale (
            .clk       (clk),
            .load_prod (load[0]),
            .load_term (load[1]),
            .raw       (raw[s]),
            .gain      (gain_reg[s]),
            .bipolar   (bipolar_mask_reg[s]),
            .term      (terms_s1[s])
        );
    end

    assign terms_pipe[0] = terms_s1;
    assign acc_pipe[0]   = '{bipolar: 1'b0, value: '0};

    // Combine chain: stage k folds in source k and forwards the remaining terms.
    for (genvar k = 0; k < MAX_SOURCES; k++) begin : g_comb
        msc_combine #(
            .NUM_SRC (MAX_SOURCES)
        ) u_combine (
            .clk       (clk),
            .load      (load[2+k]),
            .active    (COUNT_W'(k) < count_eff),
            .bipolar   (bipolar_mask_reg[k]),
            .mode      (combine_modes_reg[MODE_W*k +: MODE_W]),
            .term      ($signed(terms_pipe[k][k])),
            .terms_in  (terms_pipe[k]),
            .acc_in    (acc_pipe[k]),
            .terms_out (terms_pipe[k+1]),
            .acc_out   (acc_pipe[k+1])
        );
    end

    assign src_ready      = rdy[0];
    assign res_valid      = vld_reg[NST-1];
    assign combined_value = acc_pipe[MAX_SOURCES].value;

    // An accepted transaction always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready |=> vld_reg[0])
        else $error("accepted transaction missing from first stage");

    // With the output register empty, the whole pipeline can move.
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> src_ready)
        else $error("source side blocked while output is empty");

    // A blocked first stage keeps its transaction and refuses a new one.
    a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && !rdy[1] |=> vld_reg[0])
        else $error("first stage dropped a blocked transaction");

    a_first_block: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && !rdy[1] |-> !src_ready)
        else $error("source accepted into a blocked first stage");

endmodule

/* bench/tb_modulation_source_combiner.sv */
// Self-checking testbench for the modulation source combiner: directed and random traffic.
module tb_modulation_source_combiner;
    import msc_pkg::*;

    // Codes that fall outside the four defined modes, so the running value is kept.
    localparam logic [MODE_W-1:0] MODE_KEEP_LOW  = 4'h4;
    localparam logic [MODE_W-1:0] MODE_KEEP_HIGH = 4'hF;

    // Generous ceiling on the whole run, in clock cycles.
    localparam int LIMIT_CYCLES = 400000;
    // Length of the long receiver hold-off. It is well beyond the pipeline depth,
    // so the block fills up and has to lower src_ready.
    localparam int HOLD_CYCLES  = 64;
    // Cycles to let pass once nothing is outstanding: the pipeline depth plus margin.
    localparam int SETTLE_CYCLES = 2 + MAX_SOURCES_DEF + 4;

    typedef logic signed [RAW_W-1:0] raw_t;
    typedef raw_t sources_t [4];

    // The scoreboard keeps its own copy of the registers and, for every source
    // transaction taken by the block, works out the combined value that should
    // come back. Results are checked in order against the oldest outstanding value.
    class combiner_scoreboard;
        logic [COUNT_W-1:0]       count;
        logic [MASK_W-1:0]        bip_mask;
        logic [MODES_W-1:0]       modes;
        logic signed [GAIN_W-1:0] gain [4];
        logic [VALUE_W-1:0]       awaited_values [$];
        int                       errors;

        function new();
            count    = '0;
            bip_mask = '0;
            modes    = '0;
            foreach (gain[k])
                gain[k] = GAIN_UNITY;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SOURCE_COUNT:  count    = data[COUNT_W-1:0];
                CFG_BIPOLAR_MASK:  bip_mask = data[MASK_W-1:0];
                CFG_COMBINE_MODES: modes    = data[MODES_W-1:0];
                CFG_SCALE_ZERO:    gain[0]  = data;
                CFG_SCALE_ONE:     gain[1]  = data;
                CFG_SCALE_TWO:     gain[2]  = data;
                CFG_SCALE_THREE:   gain[3]  = data;
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // Folds the scaled sources into the running value, tracking whether
        // the running value is currently bipolar.
        function logic [VALUE_W-1:0] fold_sources(sources_t raw);
            longint             acc;
            longint             term;
            longint             prod;
            bit                 run_bip;
            bit                 src_bip;
            int                 n;
            logic [MODE_W-1:0]  mode;
            acc     = 0;
            run_bip = 1'b0;
            n       = (count > MAX_SOURCES_DEF) ? MAX_SOURCES_DEF : int'(count);
            for (int i = 0; i < n; i++) begin
                term    = (longint'(raw[i]) * (longint'(gain[i]) >>> 1)) >>> SCALE_SHIFT;
                mode    = modes[MODE_W*i +: MODE_W];
                src_bip = bip_mask[i];
                term    = src_bip ? clip(term, -8192, 8191) : clip(term, 0, 16383);
                case (mode)
                    MODE_SET: begin
                        acc     = src_bip ? term + 8192 : term;
                        run_bip = src_bip;
                    end
                    MODE_ADD: begin
                        acc = run_bip ? clip(acc + term - 8192, -8192, 8191) + 8192
                                      : clip(acc + term, 0, 16383);
                    end
                    MODE_SUB: begin
                        acc = run_bip ? clip(acc - 8192 - term, -8192, 8191) + 8192
                                      : clip(acc - term, 0, 16383);
                    end
                    MODE_MUL: begin
                        if (src_bip) begin
                            prod    = run_bip ? ((acc - 8192) * term) >>> 13
                                              : (term * acc) >>> 13;
                            run_bip = 1'b1;
                            acc     = clip(prod, -8192, 8191) + 8192;
                        end else if (run_bip) begin
                            acc = clip((term * (acc - 8192)) >>> 14, -8192, 8191) + 8192;
                        end else begin
                            acc = clip((acc * term) >>> 14, 0, 16383);
                        end
                    end
                    default: ;
                endcase
            end
            return acc[VALUE_W-1:0];
        endfunction

        function void note_sources(sources_t raw);
            awaited_values.push_back(fold_sources(raw));
        endfunction

        function void check_combined(logic [VALUE_W-1:0] got);
            logic [VALUE_W-1:0] exp_value;
            if (awaited_values.size() == 0) begin
                $error("combined_value: no transaction outstanding, actual %0d", got);
                errors++;
            end else begin
                exp_value = awaited_values.pop_front();
                if (got !== exp_value) begin
                    $error("combined_value: expected %0d, actual %0d", exp_value, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  src_valid;
    logic                  src_ready;
    raw_t                  source_zero_value;
    raw_t                  source_one_value;
    raw_t                  source_two_value;
    raw_t                  source_three_value;
    logic                  res_valid;
    logic                  res_ready;
    logic [VALUE_W-1:0]    combined_value;

    combiner_scoreboard sb;

    // Idling controls, in percent, changed by the main sequence between phases.
    int send_idle_pct;
    int stall_pct;
    // The main sequence asks for a hold-off by bumping hold_asked; the receiver
    // process notices the difference and counts the stretch down itself.
    int hold_asked;
    int hold_served;
    int hold_left;
    int cycle_count;

    modulation_source_combiner dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .src_valid          (src_valid),
        .src_ready          (src_ready),
        .source_zero_value  (source_zero_value),
        .source_one_value   (source_one_value),
        .source_two_value   (source_two_value),
        .source_three_value (source_three_value),
        .res_valid          (res_valid),
        .res_ready          (res_ready),
        .combined_value     (combined_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a correct run finishes far inside this limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver side. Ready changes only at the falling edge; it stalls at random
    // according to stall_pct, or holds off completely during a requested stretch.
    always @(negedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            res_ready = 1'b0;
            hold_left--;
        end
        else
        begin
            res_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: every handshake is observed at the rising edge. A result is
    // checked before the transaction of the same edge is noted, since no
    // transaction can come out in the cycle it goes in.
    always @(posedge clk)
    begin
        sources_t taken;
        if (rst_n)
        begin
            if (res_valid && res_ready)
                sb.check_combined(combined_value);
            if (src_valid && src_ready)
            begin
                taken[0] = source_zero_value;
                taken[1] = source_one_value;
                taken[2] = source_two_value;
                taken[3] = source_three_value;
                sb.note_sources(taken);
            end
        end
    end

    // One register write per cycle; the scoreboard copy is updated alongside,
    // which is safe because writes only happen while the block is empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [COUNT_W-1:0] count, input logic [MASK_W-1:0] mask,
                             input logic [MODES_W-1:0] modes,
                             input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                             input logic [GAIN_W-1:0] g2, input logic [GAIN_W-1:0] g3);
        write_reg(CFG_SOURCE_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_BIPOLAR_MASK, CFG_DATA_W'(mask));
        write_reg(CFG_COMBINE_MODES, CFG_DATA_W'(modes));
        write_reg(CFG_SCALE_ZERO, g0);
        write_reg(CFG_SCALE_ONE, g1);
        write_reg(CFG_SCALE_TWO, g2);
        write_reg(CFG_SCALE_THREE, g3);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Offers one source transaction, after a random number of idle cycles, and
    // returns at the rising edge on which it is accepted. Valid stays high and
    // the payload stays put until then.
    task automatic send_four(input raw_t a, input raw_t b, input raw_t c, input raw_t d);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            src_valid = 1'b0;
            @(negedge clk);
        end
        src_valid          = 1'b1;
        source_zero_value  = a;
        source_one_value   = b;
        source_two_value   = c;
        source_three_value = d;
        do
            @(posedge clk);
        while (!src_ready);
    endtask

    // Lowers valid after the last transaction of a phase and waits until every
    // expected result has come back and the pipeline has settled.
    task automatic wait_drained();
        @(negedge clk);
        src_valid = 1'b0;
        while (sb.awaited_values.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Full-scale positive, full-scale negative, and a mix of small values.
    task automatic directed_trio();
        send_four(17'sd65535, 17'sd65535, 17'sd65535, 17'sd65535);
        send_four(-17'sd65536, -17'sd65536, -17'sd65536, -17'sd65536);
        send_four(17'sd0, -17'sd1, 17'sd4096, -17'sd8192);
    endtask

    // Raw values: full range, the useful middle, the extremes, or modest values.
    function automatic raw_t rand_raw();
        raw_t r;
        case ($urandom_range(3))
            0: r = raw_t'($urandom);
            1: r = raw_t'(int'($urandom_range(32767)) - 16384);
            2: begin
                case ($urandom_range(3))
                    0: r = 17'sd65535;
                    1: r = -17'sd65536;
                    2: r = 17'sd0;
                    default: r = -17'sd1;
                endcase
            end
            default: r = raw_t'(int'($urandom_range(8191)) - 4096);
        endcase
        return r;
    endfunction

    // Gains: unity, the documented range, its corners, or any 18-bit pattern now and then.
    function automatic logic [GAIN_W-1:0] rand_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(9))
            0, 1, 2: g = GAIN_UNITY;
            3, 4, 5, 6: g = GAIN_W'(int'($urandom_range(131072)) - 65536);
            7, 8: begin
                case ($urandom_range(4))
                    0: g = GAIN_W'(-65536);
                    1: g = GAIN_W'(65536);
                    2: g = '0;
                    3: g = GAIN_W'(-1);
                    default: g = GAIN_W'(1);
                endcase
            end
            default: g = GAIN_W'($urandom);
        endcase
        return g;
    endfunction

    initial
    begin
        logic [COUNT_W-1:0] count;
        logic [MODES_W-1:0] modes;
        int                 r;

        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        src_valid          = 1'b0;
        source_zero_value  = '0;
        source_one_value   = '0;
        source_two_value   = '0;
        source_three_value = '0;
        res_ready          = 1'b0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        hold_asked         = 0;
        hold_served        = 0;
        hold_left          = 0;
        cycle_count        = 0;
        sb                 = new();

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Registers as left by reset: no sources, so the value is always zero.
        send_four(17'sd65535, -17'sd65536, 17'sd1, -17'sd1);
        send_four(-17'sd65536, 17'sd65535, 17'sd0, 17'sd0);
        wait_drained();

        // Every mode once, with bipolar and unipolar sources interleaved.
        configure(3'd4, 4'b0101, {MODE_SUB, MODE_MUL, MODE_ADD, MODE_SET},
                  GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY);
        directed_trio();
        wait_drained();

        // All sources bipolar, with gains at both ends of the range.
        configure(3'd4, 4'b1111, {MODE_SUB, MODE_MUL, MODE_ADD, MODE_SET},
                  GAIN_W'(-65536), GAIN_W'(65536), GAIN_W'(32768), GAIN_W'(1));
        directed_trio();
        wait_drained();

        // Two unipolar multiplies, both on a bipolar running value.
        configure(3'd4, 4'b0001, {MODE_MUL, MODE_ADD, MODE_MUL, MODE_SET},
                  GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY);
        directed_trio();
        wait_drained();

        // A count above the number of sources is cut back to four; unknown
        // codes in every slot leave the running value at zero.
        configure(3'd7, 4'b1111, {MODE_KEEP_HIGH, MODE_KEEP_HIGH, MODE_KEEP_HIGH, MODE_KEEP_LOW},
                  '0, GAIN_W'(-1), GAIN_UNITY, GAIN_W'(-65536));
        directed_trio();
        wait_drained();

        // Bipolar multiply straight onto the unipolar start, with full-width gains.
        configure(3'd4, 4'b1111, {MODE_MUL, MODE_MUL, MODE_MUL, MODE_MUL},
                  GAIN_W'(131071), GAIN_W'(-131072), GAIN_W'(-65536), GAIN_W'(65536));
        directed_trio();
        wait_drained();

        // Random phases. The idling pattern rotates through none, sender idle,
        // receiver stalling and both; two of the unthrottled phases also get a
        // long receiver hold-off so that the block backs up to its input.
        for (int phase = 0; phase < 12; phase++)
        begin
            r = $urandom_range(9);
            if (r == 0)
                count = 3'd0;
            else if (r >= 8)
                count = COUNT_W'($urandom_range(5, 7));
            else
                count = COUNT_W'($urandom_range(1, 4));
            for (int k = 0; k < 4; k++)
                modes[MODE_W*k +: MODE_W] = ($urandom_range(9) < 9)
                    ? MODE_W'($urandom_range(MODE_SET, MODE_SUB))
                    : MODE_W'($urandom_range(MODE_KEEP_LOW, MODE_KEEP_HIGH));
            configure(count, MASK_W'($urandom), modes,
                      rand_gain(), rand_gain(), rand_gain(), rand_gain());

            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            if (phase == 0 || phase == 8)
                hold_asked++;

            for (int n = 0; n < 100; n++)
                send_four(rand_raw(), rand_raw(), rand_raw(), rand_raw());
            wait_drained();
        end

        // Everything has been taken; give any stray result a chance to show up.
        while (sb.awaited_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
